[src/dmc_pkg.sv]
package dmc_pkg;

  // Width of the sticky fault code held inside the block.
  localparam int unsigned FAULT_WIDTH = 8;

  // Width of the driver status field and of the reported fault value.
  localparam int unsigned STATUS_WIDTH = 8;

  // All eight codes are real modes.
  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_RUN      = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_LP_ENTER = 3'd3,
    MODE_LP       = 3'd4,
    MODE_LP_EXIT  = 3'd5,
    MODE_FAULT    = 3'd6,
    MODE_RESET    = 3'd7
  } mode_t;

  typedef struct packed {
    logic                    write_request;
    logic                    low_power_set;
    logic                    low_power_clear;
    logic                    reset_request;
    logic [STATUS_WIDTH-1:0] driver_status;
  } dmc_in_t;

  typedef struct packed {
    logic [2:0]              entered_state;
    logic [STATUS_WIDTH-1:0] fault_value;
    logic                    write_pending;
    logic                    low_power_pending;
    logic                    reset_pending;
  } dmc_out_t;

  // Controller state carried from one word to the next.
  typedef struct packed {
    mode_t                  mode;
    logic [FAULT_WIDTH-1:0] fault;
    logic                   write_flag;
    logic                   low_power_flag;
    logic                   reset_flag;
    logic                   startup_flag;
  } dmc_state_t;

endpackage

[src/dmc_step.sv]
module dmc_step (
  input  dmc_pkg::dmc_state_t cur_i,
  input  dmc_pkg::dmc_in_t    item_i,
  output dmc_pkg::dmc_state_t nxt_o,
  output dmc_pkg::dmc_out_t   result_o
);
  import dmc_pkg::*;

  logic                   w_flag;
  logic                   lp_flag;
  logic                   r_flag;
  logic [FAULT_WIDTH-1:0] fault_acc;
  logic                   f_any;
  mode_t                  next_mode;

  // Latch the requests; a clear of the low power flag wins over a set.
  always_comb begin
    w_flag    = cur_i.write_flag | item_i.write_request;
    lp_flag   = item_i.low_power_clear ? 1'b0 :
                (cur_i.low_power_flag | item_i.low_power_set);
    r_flag    = cur_i.reset_flag | item_i.reset_request;
    fault_acc = cur_i.fault | FAULT_WIDTH'(item_i.driver_status);
    f_any     = |fault_acc;
  end

  // Mode selection; from run the priority is fault, then reset, then low power, then write.
  always_comb begin
    next_mode = MODE_INIT;
    case (cur_i.mode)
      MODE_INIT: begin
        next_mode = cur_i.startup_flag ? MODE_INIT : MODE_RUN;
      end
      MODE_RUN: begin
        if (f_any) begin
          next_mode = MODE_FAULT;
        end else if (r_flag) begin
          next_mode = MODE_RESET;
        end else if (lp_flag) begin
          next_mode = MODE_LP_ENTER;
        end else if (w_flag) begin
          next_mode = MODE_WRITE;
        end else begin
          next_mode = MODE_RUN;
        end
      end
      MODE_WRITE, MODE_LP_EXIT: begin
        if (f_any) begin
          next_mode = MODE_FAULT;
        end else if (r_flag) begin
          next_mode = MODE_RESET;
        end else begin
          next_mode = MODE_RUN;
        end
      end
      MODE_LP_ENTER: begin
        next_mode = MODE_LP;
      end
      MODE_LP: begin
        next_mode = (f_any || r_flag || !lp_flag) ? MODE_LP_EXIT : MODE_LP;
      end
      MODE_FAULT: begin
        if (r_flag) begin
          next_mode = MODE_RESET;
        end else if (!f_any) begin
          next_mode = MODE_RUN;
        end else begin
          next_mode = MODE_FAULT;
        end
      end
      default: begin
        next_mode = MODE_INIT;
      end
    endcase
  end

  // Flag effects of the mode just entered.
  always_comb begin
    nxt_o.mode           = next_mode;
    nxt_o.fault          = fault_acc;
    nxt_o.write_flag     = w_flag;
    nxt_o.low_power_flag = lp_flag;
    nxt_o.reset_flag     = r_flag;
    nxt_o.startup_flag   = cur_i.startup_flag;
    case (next_mode)
      MODE_INIT: begin
        nxt_o.reset_flag   = 1'b0;
        nxt_o.startup_flag = 1'b0;
      end
      MODE_WRITE: begin
        nxt_o.write_flag = 1'b0;
      end
      MODE_LP_EXIT: begin
        nxt_o.low_power_flag = 1'b0;
      end
      MODE_RESET: begin
        nxt_o.fault = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.entered_state     = next_mode;
    result_o.fault_value       = STATUS_WIDTH'(nxt_o.fault);
    result_o.write_pending     = nxt_o.write_flag;
    result_o.low_power_pending = nxt_o.low_power_flag;
    result_o.reset_pending     = nxt_o.reset_flag;
  end

endmodule

[src/display_mode_controller_fsm.sv]
// Display mode controller. Each input word is one controller tick carrying
// the write, low power and reset requests plus the driver status bits; each
// tick yields exactly one result word holding the mode just entered, the
// sticky fault code and the pending flags, and entered_state selects the
// screen action to run outside the block. The block takes one word per clock
// and answers in the cycle after acceptance: all of a tick's work is a short
// piece of logic feeding the mode state and the result register. A new word
// is let in whenever the result register is empty or its word is taken in
// that same cycle, so throughput stays at one word per cycle as long as the
// result side keeps taking words; while the result side stalls with a word
// waiting, the input is held off. After reset the controller sits in init
// with the startup flag set, so the first tick stays in init and clears it.
module display_mode_controller_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dmc_pkg::dmc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dmc_pkg::dmc_out_t out_data
);
  import dmc_pkg::*;

  dmc_state_t state_r;
  dmc_state_t state_nxt;
  dmc_out_t   step_result;
  dmc_out_t   out_data_r;
  logic       out_valid_r;
  logic       in_fire;

  // A word may enter whenever the result register is empty or is being
  // drained in this same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Next mode, flag effects and the result word for the incoming tick.
  dmc_step u_step (
    .cur_i    (state_r),
    .item_i   (in_data),
    .nxt_o    (state_nxt),
    .result_o (step_result)
  );

  // Mode and flag register; it advances only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode           <= MODE_INIT;
      state_r.fault          <= '0;
      state_r.write_flag     <= 1'b0;
      state_r.low_power_flag <= 1'b0;
      state_r.reset_flag     <= 1'b0;
      state_r.startup_flag   <= 1'b1;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register. The valid bit is control state; the payload is loaded
  // with each accepted tick and holds while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entering reset always clears the fault code.
  a_reset_clears_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.entered_state == MODE_RESET) |->
      (out_data_r.fault_value == '0))
    else $error("reset mode reported with a nonzero fault code");

  // Entering init always leaves the reset flag clear.
  a_init_clears_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.entered_state == MODE_INIT) |->
      !out_data_r.reset_pending)
    else $error("init mode reported with reset still pending");

  // Entering write consumes the pending write.
  a_write_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.entered_state == MODE_WRITE) |->
      !out_data_r.write_pending)
    else $error("write mode reported with write still pending");

  // Low power enter always moves on to low power on the next tick.
  a_lp_enter_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r.mode == MODE_LP_ENTER) |=> (state_r.mode == MODE_LP))
    else $error("low power enter did not advance to low power");

  // The result register reflects the mode register after every tick.
  a_result_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && (out_data_r.entered_state == state_r.mode))
    else $error("result word disagrees with the mode register");

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  // The receiver holds off this long once the fill test asks for it.
  localparam int HOLD_CYCLES = 60;
  // How long the end of the run may wait for the last result words.
  localparam int DRAIN_LIMIT = 2000;
  // Extra cycles after the last expected word, to catch stray results.
  localparam int SETTLE_CYCLES = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dmc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dmc_out_t out_data;

  // Controller state as the testbench believes it to be after each accepted
  // word, and the reports that the block still owes us, oldest first.
  dmc_state_t ctl_now;
  dmc_out_t   mode_reports[$];

  int   mismatches = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   pattern_left = 0;
  int   stall_pct = 0;

  display_mode_controller_fsm DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Runs one controller tick on the shadow state and returns the report that
  // the block must produce for it. The order matters: requests are latched
  // first, then the status is folded into the fault code, then the next mode
  // is chosen from the updated flags, and only then does the mode entered
  // apply its own flag effects.
  function automatic dmc_out_t next_mode_report(dmc_in_t w);
    logic [FAULT_WIDTH-1:0] status_bits;
    logic                   f;
    logic                   r;
    logic                   l;
    logic                   wr;
    mode_t                  nxt;
    dmc_out_t               rep;
    if (w.write_request) ctl_now.write_flag = 1'b1;
    if (w.low_power_set) ctl_now.low_power_flag = 1'b1;
    // Clear is applied after set, so it wins when both bits arrive together.
    if (w.low_power_clear) ctl_now.low_power_flag = 1'b0;
    if (w.reset_request) ctl_now.reset_flag = 1'b1;
    status_bits = w.driver_status;
    ctl_now.fault = ctl_now.fault | status_bits;

    f  = |ctl_now.fault;
    r  = ctl_now.reset_flag;
    l  = ctl_now.low_power_flag;
    wr = ctl_now.write_flag;

    // Priority from run: fault, then reset, then low power, then write; write
    // and low power exit check fault before reset, and fault checks reset first.
    case (ctl_now.mode)
      MODE_INIT: begin
        if (ctl_now.startup_flag) nxt = MODE_INIT;
        else nxt = MODE_RUN;
      end
      MODE_RUN: begin
        if (f) nxt = MODE_FAULT;
        else if (r) nxt = MODE_RESET;
        else if (l) nxt = MODE_LP_ENTER;
        else if (wr) nxt = MODE_WRITE;
        else nxt = MODE_RUN;
      end
      MODE_WRITE, MODE_LP_EXIT: begin
        if (f) nxt = MODE_FAULT;
        else if (r) nxt = MODE_RESET;
        else nxt = MODE_RUN;
      end
      MODE_LP_ENTER: nxt = MODE_LP;
      MODE_LP: begin
        if (f || r || !l) nxt = MODE_LP_EXIT;
        else nxt = MODE_LP;
      end
      MODE_FAULT: begin
        if (r) nxt = MODE_RESET;
        else if (!f) nxt = MODE_RUN;
        else nxt = MODE_FAULT;
      end
      default: nxt = MODE_INIT;
    endcase

    case (nxt)
      MODE_INIT: begin
        ctl_now.reset_flag = 1'b0;
        ctl_now.startup_flag = 1'b0;
      end
      MODE_WRITE:   ctl_now.write_flag = 1'b0;
      MODE_LP_EXIT: ctl_now.low_power_flag = 1'b0;
      MODE_RESET:   ctl_now.fault = '0;
      default: ;
    endcase
    ctl_now.mode = nxt;

    rep.entered_state     = nxt;
    rep.fault_value       = ctl_now.fault;
    rep.write_pending     = ctl_now.write_flag;
    rep.low_power_pending = ctl_now.low_power_flag;
    rep.reset_pending     = ctl_now.reset_flag;
    return rep;
  endfunction

  function automatic dmc_in_t tick_of(bit wr, bit lps, bit lpc, bit rr,
                                      logic [STATUS_WIDTH-1:0] status);
    dmc_in_t w;
    w.write_request   = wr;
    w.low_power_set   = lps;
    w.low_power_clear = lpc;
    w.reset_request   = rr;
    w.driver_status   = status;
    return w;
  endfunction

  // A plausible tick: the status is mostly clean so that the machine spends
  // time in run, write and low power, with occasional faults and enough reset
  // requests to get back out of the fault mode. A noisy tick has every field
  // uniformly random instead.
  function automatic dmc_in_t random_tick(bit noisy);
    dmc_in_t w;
    int      pick;
    if (noisy) begin
      w.write_request   = 1'($urandom_range(1, 0));
      w.low_power_set   = 1'($urandom_range(1, 0));
      w.low_power_clear = 1'($urandom_range(1, 0));
      w.reset_request   = 1'($urandom_range(1, 0));
      w.driver_status   = STATUS_WIDTH'($urandom_range(255, 0));
    end else begin
      w.write_request   = ($urandom_range(99, 0) < 30);
      w.low_power_set   = ($urandom_range(99, 0) < 15);
      w.low_power_clear = ($urandom_range(99, 0) < 12);
      w.reset_request   = ($urandom_range(99, 0) < 7);
      pick = $urandom_range(99, 0);
      if (pick < 85) w.driver_status = '0;
      else if (pick < 93)
        w.driver_status = STATUS_WIDTH'(1 << $urandom_range(STATUS_WIDTH - 1, 0));
      else w.driver_status = STATUS_WIDTH'($urandom_range(255, 1));
    end
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is only
  // lowered when a gap between bursts starts; back-to-back words keep it high,
  // so it never gets two assignments in one step.
  task automatic send_tick(dmc_in_t word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = gaps_on ? $urandom_range(6, 0) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!(in_valid && in_ready));
    mode_reports.push_back(next_mode_report(word));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result side: a ready pattern that switches at random intervals
  // between always ready, light stalls and heavy stalls. A hold request from
  // the fill test overrides it with a long stretch of not ready.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(300, 40);
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 70;
        endcase
      end else begin
        pattern_left--;
      end
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Every word taken from the result side is matched against the oldest
  // outstanding report, one field at a time.
  always @(posedge clk) begin : result_check
    dmc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (mode_reports.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_data), 0);
      end else begin
        want = mode_reports.pop_front();
        if (out_data.entered_state !== want.entered_state)
          report_mismatch("entered_state", out_data.entered_state, want.entered_state);
        if (out_data.fault_value !== want.fault_value)
          report_mismatch("fault_value", out_data.fault_value, want.fault_value);
        if (out_data.write_pending !== want.write_pending)
          report_mismatch("write_pending", out_data.write_pending, want.write_pending);
        if (out_data.low_power_pending !== want.low_power_pending)
          report_mismatch("low_power_pending", out_data.low_power_pending,
                          want.low_power_pending);
        if (out_data.reset_pending !== want.reset_pending)
          report_mismatch("reset_pending", out_data.reset_pending, want.reset_pending);
      end
    end
  end

  // Walks every mode along these paths: the startup tick that stays in
  // init, write, the low power round trip left by both bits at once, by a
  // reset request and by a fault, the sticky fault with all-ones and
  // single-bit status, and the reset path back through init.
  task automatic test_directed_paths;
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // startup tick stays in init
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // init to run
    send_tick(tick_of(1, 0, 0, 0, 8'h00));  // run to write
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // write to run
    send_tick(tick_of(0, 1, 0, 0, 8'h00));  // low power enter
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // low power
    send_tick(tick_of(0, 1, 1, 0, 8'h00));  // both bits, clear wins: exit
    send_tick(tick_of(1, 1, 0, 0, 8'h00));  // exit to run, low power and write pending
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // low power outranks write
    send_tick(tick_of(0, 0, 0, 1, 8'h00));  // enter always goes on to low power
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // reset request forces an exit
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // exit to reset
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // reset to init, reset flag cleared
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // init to run
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // leftover write request served
    send_tick(tick_of(0, 0, 0, 0, 8'h80));  // top status bit: write to fault
    send_tick(tick_of(0, 0, 0, 0, 8'h01));  // fault is sticky and accumulates
    send_tick(tick_of(0, 0, 0, 1, 8'h00));  // fault to reset, fault code cleared
    send_tick(tick_of(0, 1, 0, 0, 8'h00));  // reset to init
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // init to run
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // low power enter
    send_tick(tick_of(0, 0, 0, 0, 8'h00));  // low power
    send_tick(tick_of(0, 0, 0, 0, 8'hFF));  // all status bits force an exit
    send_tick(tick_of(1, 0, 0, 0, 8'h00));  // exit to fault
    send_tick(tick_of(0, 0, 0, 1, 8'h00));  // fault to reset
  endtask

  // The receiver stops for a long stretch while words keep coming with no
  // gaps, so the block has to fill and drop in_ready.
  task automatic test_backpressure_fill;
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    repeat (20) send_tick(random_tick(1'b0));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_ticks(int count);
    for (int i = 0; i < count; i++) begin
      // Every so often switch to a stretch without sender gaps.
      if (i % 200 == 100) gaps_on = 1'b0;
      else if (i % 200 == 0) gaps_on = 1'b1;
      send_tick(random_tick(1'b0));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_noise(int count);
    repeat (count) send_tick(random_tick(1'b1));
  endtask

  // Lets the block hand over everything still owed, waits a few more cycles
  // for anything unexpected, then gives the verdict.
  task automatic finish_run;
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (mode_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (mode_reports.size() != 0) begin
      $display("%0t: %0d result words never arrived", $realtime, mode_reports.size());
      $display("FAIL display_mode_controller_fsm");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (mismatches == 0) begin
        $display("PASS display_mode_controller_fsm");
      end else begin
        $display("FAIL display_mode_controller_fsm");
      end
      $finish;
    end
  endtask

  initial begin
    ctl_now = '{mode: MODE_INIT, fault: '0, write_flag: 1'b0, low_power_flag: 1'b0,
                reset_flag: 1'b0, startup_flag: 1'b1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_paths();
    test_backpressure_fill();
    test_random_ticks(1000);
    test_random_noise(120);
    finish_run();
  end

  // Hard stop far beyond the slowest plausible run.
  initial begin
    #4_000_000;
    $display("%0t: run did not complete", $realtime);
    $display("FAIL display_mode_controller_fsm");
    $finish;
  end

endmodule
